@@ design/ddo_pkg.sv @@
// shared types, constants and arithmetic helpers for the odometry block
package ddo_pkg;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic        [15:0] step_time;
    logic               use_imu;
    logic signed [23:0] gyro_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
  } out_item_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] cos_v;
    logic signed [32:0] sin_v;
  } cs_res_t;

  localparam logic [3:0] REG_LEFT_STEP  = 4'd0;
  localparam logic [3:0] REG_RIGHT_STEP = 4'd1;
  localparam logic [3:0] REG_INV_TRACK  = 4'd2;
  localparam logic [3:0] REG_IMU_WEIGHT = 4'd3;

  localparam logic [31:0] LEFT_STEP_RST  = 32'd2657000;
  localparam logic [31:0] RIGHT_STEP_RST = 32'd2657000;
  localparam logic [23:0] INV_TRACK_RST  = 24'd327680;
  localparam logic [16:0] IMU_W_RST      = 17'd62259;
  localparam logic [16:0] W_ONE          = 17'd65536;

  localparam logic signed [33:0] TWO_PI   = 34'sd411775;
  localparam logic signed [33:0] PI_Q     = 34'sd205887;
  localparam logic signed [33:0] HALF_PI  = 34'sd102944;
  localparam logic signed [33:0] MOD_BIAS = 34'sd2147818400;
  localparam logic signed [33:0] GAIN_Q30 = 34'sh026DD3B6A;
  localparam logic [4:0] MOD_TOP   = 5'd13;
  localparam logic [4:0] ROT_LAST  = 5'd23;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    unique case (i)
      5'd0:  return 34'sh03243F6A8;
      5'd1:  return 34'sh01DAC6705;
      5'd2:  return 34'sh00FADBAFC;
      5'd3:  return 34'sh007F56EA6;
      5'd4:  return 34'sh003FEAB76;
      5'd5:  return 34'sh001FFD55B;
      5'd6:  return 34'sh000FFFAAA;
      5'd7:  return 34'sh0007FFF55;
      5'd8:  return 34'sh0003FFFEA;
      5'd9:  return 34'sh0001FFFFD;
      5'd10: return 34'sd1048575;
      5'd11: return 34'sd524287;
      5'd12: return 34'sd262143;
      5'd13: return 34'sd131071;
      5'd14: return 34'sd65535;
      5'd15: return 34'sd32767;
      5'd16: return 34'sd16383;
      5'd17: return 34'sd8191;
      5'd18: return 34'sd4095;
      5'd19: return 34'sd2047;
      5'd20: return 34'sd1023;
      5'd21: return 34'sd511;
      5'd22: return 34'sd255;
      5'd23: return 34'sd127;
      default: return 34'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
    return (p + 66'sd32768) >>> 16;
  endfunction

  function automatic logic signed [65:0] rnd30(input logic signed [65:0] p);
    return (p + 66'sd536870912) >>> 30;
  endfunction

endpackage

@@ design/diff_drive_odometry_imu_fusion.sv @@
// top level: differential drive odometry with gyro heading blend
//
// in_valid/in_ready take one item: absolute wheel counts, step time, imu flag
// and gyro rate. out_valid/out_ready hand back one item per input item with
// the new x, y and heading, all q16.16 and saturated.
// cfg_we/cfg_idx/cfg_wdata write the step lengths, inverse track width and
// imu weight; write them only while no item is in flight.
// the time from acceptance to out_valid is set by the cordic: 14 reduction
// steps and 24 rotation steps, and the imu blend adds its blend states after
// that; the wheel, heading and gyro products go through one shared multiplier
// meanwhile, the position and blend products after the cordic. one item is in
// work at a time: the next is taken once the last result is in the output register.
// in_ready is high only in the idle state. the finished item sits in the
// output register; if the receiver stalls, the next item is still taken and
// computed, and its result waits until the previous one is taken.
// synchronous reset clears x, y, the encoder and imu headings and stored counts
// to zero and loads the default configuration.
module diff_drive_odometry_imu_fusion import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_ML, S_MR, S_DR, S_TH, S_GY, S_WAIT, S_X, S_XC, S_YC, S_B1, S_B2, S_DONE
  } state_t;

  state_t state_r;
  logic [31:0] lsl_r, rsl_r;
  logic [23:0] inv_r;
  logic [16:0] imu_w_r;
  logic [31:0] last_left_r, last_right_r;
  logic signed [31:0] x_r, y_r, enc_r, imu_r, head_r;
  logic signed [31:0] dlt_r, drt_r, dl_r, adv_r;
  logic [15:0] dt_r;
  logic use_imu_r;
  logic signed [23:0] gyro_r;
  logic signed [65:0] acc_r;
  logic out_valid_r;
  out_item_t out_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] dr_c;
  logic signed [32:0] sum_c;
  logic [16:0] w_c;
  logic take_c;
  logic out_load_c;
  cs_res_t cres;

  ddo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  ddo_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(take_c), .angle(enc_r), .res(cres)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign take_c     = in_valid && in_ready;
  assign out_load_c = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_comb begin
    w_c   = (imu_w_r > W_ONE) ? W_ONE : imu_w_r;
    dr_c  = sat32(rnd16(prod));
    sum_c = {dl_r[31], dl_r} + {dr_c[31], dr_c};
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ML: begin mul_a = {dlt_r[31], dlt_r}; mul_b = {1'b0, lsl_r}; end
      S_MR: begin mul_a = {drt_r[31], drt_r}; mul_b = {1'b0, rsl_r}; end
      S_DR: begin
        mul_a = {dr_c[31], dr_c} - {dl_r[31], dl_r};
        mul_b = {9'd0, inv_r};
      end
      S_TH: begin mul_a = {{9{gyro_r[23]}}, gyro_r}; mul_b = {17'd0, dt_r}; end
      S_X:  begin mul_a = {adv_r[31], adv_r}; mul_b = cres.cos_v; end
      S_XC: begin mul_a = {adv_r[31], adv_r}; mul_b = cres.sin_v; end
      S_YC: begin mul_a = {imu_r[31], imu_r}; mul_b = {16'd0, w_c}; end
      S_B1: begin mul_a = {enc_r[31], enc_r}; mul_b = {16'd0, W_ONE - w_c}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      lsl_r        <= LEFT_STEP_RST;
      rsl_r        <= RIGHT_STEP_RST;
      inv_r        <= INV_TRACK_RST;
      imu_w_r      <= IMU_W_RST;
      last_left_r  <= '0;
      last_right_r <= '0;
      x_r          <= '0;
      y_r          <= '0;
      enc_r        <= '0;
      imu_r        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_LEFT_STEP)  lsl_r   <= cfg_wdata;
        if (cfg_idx == REG_RIGHT_STEP) rsl_r   <= cfg_wdata;
        if (cfg_idx == REG_INV_TRACK)  inv_r   <= cfg_wdata[23:0];
        if (cfg_idx == REG_IMU_WEIGHT) imu_w_r <= cfg_wdata[16:0];
      end
      if (out_load_c) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (take_c) begin
            // tick deltas wrap modulo 2^32
            dlt_r        <= in_data.left_count - last_left_r;
            drt_r        <= in_data.right_count - last_right_r;
            last_left_r  <= in_data.left_count;
            last_right_r <= in_data.right_count;
            dt_r         <= in_data.step_time;
            use_imu_r    <= in_data.use_imu;
            gyro_r       <= in_data.gyro_rate;
            state_r      <= S_ML;
          end
        end
        S_ML: state_r <= S_MR;
        S_MR: begin
          dl_r    <= sat32(rnd16(prod));
          state_r <= S_DR;
        end
        S_DR: begin
          adv_r   <= sum_c[32:1];
          state_r <= S_TH;
        end
        S_TH: begin
          enc_r   <= sat32({{34{enc_r[31]}}, enc_r} + rnd16(prod));
          state_r <= S_GY;
        end
        S_GY: begin
          if (use_imu_r) imu_r <= sat32({{34{imu_r[31]}}, imu_r} + rnd16(prod));
          state_r <= S_WAIT;
        end
        S_WAIT: if (cres.done) state_r <= S_X;
        S_X: state_r <= S_XC;
        S_XC: begin
          x_r     <= sat32({{34{x_r[31]}}, x_r} + rnd30(prod));
          state_r <= S_YC;
        end
        S_YC: begin
          y_r <= sat32({{34{y_r[31]}}, y_r} + rnd30(prod));
          if (use_imu_r) state_r <= S_B1;
          else begin
            head_r  <= enc_r;
            state_r <= S_DONE;
          end
        end
        S_B1: begin
          acc_r   <= prod;
          state_r <= S_B2;
        end
        S_B2: begin
          head_r  <= sat32(rnd16(acc_r + prod));
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load_c) begin
            out_r   <= '{pos_x: x_r, pos_y: y_r, heading: head_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ design/ddo_mul.sv @@
// shared signed 33x33 multiplier with registered product
module ddo_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

@@ design/ddo_cordic.sv @@
// iterative angle reduction and cordic rotation giving cos and sin in q3.30
module ddo_cordic import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output cs_res_t            res
);
  typedef enum logic [2:0] {C_IDLE, C_MOD, C_FOLD, C_ROT, C_OUT} cstate_t;

  cstate_t            state_r;
  logic [4:0]         cnt_r;
  logic signed [33:0] u_r, cx_r, cy_r, z_r;
  logic               flip_r;
  logic               done_r;
  logic signed [32:0] cos_r, sin_r;

  logic signed [33:0] sub_c, r_a, r_b, dx_c, dy_c;
  logic               flip_c;

  always_comb begin
    sub_c = TWO_PI <<< cnt_r[3:0];
    r_a = (u_r > PI_Q) ? u_r - TWO_PI : u_r;
    flip_c = 1'b0;
    r_b = r_a;
    if (r_a > HALF_PI) begin
      r_b = r_a - PI_Q;
      flip_c = 1'b1;
    end else if (r_a < -HALF_PI) begin
      r_b = r_a + PI_Q;
      flip_c = 1'b1;
    end
    dx_c = cx_r >>> cnt_r;
    dy_c = cy_r >>> cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            // bias keeps the value positive without changing it mod 2pi
            u_r     <= {{2{angle[31]}}, angle} + MOD_BIAS;
            cnt_r   <= MOD_TOP;
            done_r  <= 1'b0;
            state_r <= C_MOD;
          end
        end
        C_MOD: begin
          if (u_r >= sub_c) u_r <= u_r - sub_c;
          if (cnt_r == 5'd0) state_r <= C_FOLD;
          else cnt_r <= cnt_r - 5'd1;
        end
        C_FOLD: begin
          z_r     <= r_b <<< 14;
          cx_r    <= GAIN_Q30;
          cy_r    <= '0;
          flip_r  <= flip_c;
          cnt_r   <= '0;
          state_r <= C_ROT;
        end
        C_ROT: begin
          if (!z_r[33]) begin
            cx_r <= cx_r - dy_c;
            cy_r <= cy_r + dx_c;
            z_r  <= z_r - atan_q30(cnt_r);
          end else begin
            cx_r <= cx_r + dy_c;
            cy_r <= cy_r - dx_c;
            z_r  <= z_r + atan_q30(cnt_r);
          end
          if (cnt_r == ROT_LAST) state_r <= C_OUT;
          else cnt_r <= cnt_r + 5'd1;
        end
        C_OUT: begin
          cos_r   <= flip_r ? 33'(-cx_r) : cx_r[32:0];
          sin_r   <= flip_r ? 33'(-cy_r) : cy_r[32:0];
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign res = '{done: done_r, cos_v: cos_r, sin_v: sin_r};
endmodule

@@ design/ddo_chk.sv @@
// port-level checker for the odometry block, bound to the top level
module ddo_chk import ddo_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data,
  input logic        cfg_we,
  input logic [3:0]  cfg_idx,
  input logic [31:0] cfg_wdata
);
  // one item at a time: busy right after an item is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an item was taken");

  // a result never appears in the cycle after an item is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not idle after reset");
endmodule

bind diff_drive_odometry_imu_fusion ddo_chk u_ddo_chk (.*);
